// ----- hw/rtl/cmm_pkg.sv -----
// Shared constants, types and codes of the confusion-matrix metrics core.
`default_nettype none
package cmm_pkg;
   localparam int CW    = 32;               // counter width
   localparam int FB    = 16;               // fraction bits of the metrics
   localparam int TW    = CW + 2;           // total sample width
   localparam int MW    = CW + 1;           // marginal width
   localparam int QW    = CW + 3;           // width of a ratio numerator or denominator
   localparam int UW    = 4 * CW + 6;       // datapath width of the shared unit
   localparam int STEPW = $clog2(4 * CW + 2 * FB + 1);
   localparam int KW    = $clog2(FB + 1);
   localparam int RW    = FB + 1;           // unsigned metric width
   localparam int SW    = FB + 2;           // signed metric width

   localparam logic [RW-1:0] ONE_Q = RW'(1) << FB;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic             start;
      alu_op_type       op;
      logic [STEPW-1:0] steps;
   } alu_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_SQRT,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      J_ACC,
      J_PRE,
      J_REC,
      J_SPE,
      J_F1,
      J_HMUL,
      J_HDIV,
      J_AB1,
      J_AB2,
      J_MSQ,
      J_D1,
      J_D2,
      J_D3,
      J_YDIV
   } job_type;
endpackage
`default_nettype wire

// ----- hw/rtl/cmm_alu.sv -----
// Bit-serial shift-add multiplier and restoring divider shared by all metrics.
`default_nettype none
module cmm_alu (
   input  wire                       clock,
   input  wire                       reset,
   input  cmm_pkg::alu_ctl_type      ctl,
   input  wire  [cmm_pkg::UW-1:0]    acc_init,
   input  wire  [cmm_pkg::UW-1:0]    opa_init,
   input  wire  [cmm_pkg::UW-1:0]    opb_init,
   output logic                      busy,
   output logic [cmm_pkg::UW-1:0]    acc,
   output logic [cmm_pkg::UW-1:0]    opb
);
   import cmm_pkg::*;

   logic [UW-1:0]    acc_ff, acc_in;
   logic [UW-1:0]    opa_ff, opa_in;
   logic [UW-1:0]    opb_ff, opb_in;
   alu_op_type       op_ff, op_in;
   logic [STEPW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [UW-1:0]    rem_sh;
   logic             ge;

   always_comb begin
      rem_sh = {acc_ff[UW-2:0], opb_ff[UW-1]};
      ge     = rem_sh >= opa_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         acc_in  = acc_init;
         opa_in  = opa_init;
         opb_in  = opb_init;
         op_in   = ctl.op;
         cnt_in  = ctl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            if (opb_ff[0]) acc_in = acc_ff + opa_ff;
            opa_in = {opa_ff[UW-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[UW-1:1]};
         end else begin
            acc_in = ge ? rem_sh - opa_ff : rem_sh;
            opb_in = {opb_ff[UW-2:0], ge};
         end
         cnt_in = cnt_ff - STEPW'(1);
         if (cnt_ff == STEPW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      op_ff  <= op_in;
   end

   assign busy = busy_ff;
   assign acc  = acc_ff;
   assign opb  = opb_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/confusion_matrix_metrics_core.sv -----
// Top level: confusion-matrix counters, metric sequencer and result register.
`default_nettype none
// Each accepted beat updates one of four saturating 32-bit counters (or clears
// them all) and then produces one result beat with the counts, their sum and
// seven Q1.16 metrics. All ratios, the products behind the Matthews
// correlation and its wide quotient run one bit per cycle on a single shared
// shift-add / restoring-divide unit, followed by a 17-step square-root search:
// fourteen passes (five 16-step ratios, a 17-step and a 34-step pass for the
// harmonic mean, 32+32+64+3x33 multiply steps, a 160-step divide), each with
// its own start and wait states, then the square-root search and the load of
// the result. The block takes one item at a time and is ready again in the
// cycle after the result is loaded; a finished result waits in the output
// register until taken, and the next one waits behind it.
module confusion_matrix_metrics_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [1:0]              req_func,
   input  wire                     req_predicted_positive,
   input  wire                     req_actual_positive,
   input  wire  [15:0]             req_batch_count,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [cmm_pkg::CW-1:0]  rsp_true_pos,
   output logic [cmm_pkg::CW-1:0]  rsp_false_pos,
   output logic [cmm_pkg::CW-1:0]  rsp_false_neg,
   output logic [cmm_pkg::CW-1:0]  rsp_true_neg,
   output logic [cmm_pkg::TW-1:0]  rsp_total_samples,
   output logic [cmm_pkg::RW-1:0]  rsp_accuracy,
   output logic [cmm_pkg::RW-1:0]  rsp_precision,
   output logic [cmm_pkg::RW-1:0]  rsp_recall,
   output logic [cmm_pkg::RW-1:0]  rsp_specificity,
   output logic [cmm_pkg::RW-1:0]  rsp_f1_score,
   output logic signed [cmm_pkg::SW-1:0] rsp_mcc,
   output logic [cmm_pkg::RW-1:0]  rsp_sens_spec_mean
);
   import cmm_pkg::*;

   state_type     state_ff, state_in;
   job_type       job_ff, job_in;
   logic [CW-1:0] tp_ff, tp_in, fp_ff, fp_in, fn_ff, fn_in, tn_ff, tn_in;

   logic [RW-1:0]     acc_q_ff, acc_q_in, pre_ff, pre_in, rec_ff, rec_in;
   logic [RW-1:0]     spe_ff, spe_in, f1_ff, f1_in, hm_ff, hm_in;
   logic [2*FB:0]     prod_ff, prod_in;
   logic [2*CW-1:0]   aba_ff, aba_in, abb_ff, abb_in;
   logic              neg_ff, neg_in;
   logic [4*CW-1:0]   msq_ff, msq_in;
   logic [UW-1:0]     d_ff, d_in;
   logic [2*FB:0]     y_ff, y_in;
   logic [RW-1:0]     q_ff, q_in;
   logic [KW-1:0]     k_ff, k_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     o_tp_ff, o_fp_ff, o_fn_ff, o_tn_ff;
   logic [TW-1:0]     o_tot_ff;
   logic [RW-1:0]     o_acc_ff, o_pre_ff, o_rec_ff, o_spe_ff, o_f1_ff, o_hm_ff;
   logic [SW-1:0]     o_mcc_ff;
   logic              load_out;

   alu_ctl_type       ctl;
   logic [UW-1:0]     acc_init, opa_init, opb_init, alu_acc, alu_opb;
   logic              alu_busy;

   logic [CW-1:0]     cur, upd;
   logic [CW:0]       sum_add;
   logic [TW-1:0]     total;
   logic [MW-1:0]     p1, p2, p3, p4;
   logic [QW-1:0]     num_q, den_q;
   logic [RW-1:0]     qres;
   logic [FB+1:0]     rs_sum;
   logic [2*CW-1:0]   mag;
   logic [RW-1:0]     cand;
   logic [2*FB+1:0]   cand_sq;
   logic [SW-1:0]     mcc_val;

   cmm_alu u_alu (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .acc_init (acc_init),
      .opa_init (opa_init),
      .opb_init (opb_init),
      .busy     (alu_busy),
      .acc      (alu_acc),
      .opb      (alu_opb)
   );

   always_comb begin
      total  = TW'(tp_ff) + TW'(fp_ff) + TW'(fn_ff) + TW'(tn_ff);
      p1     = MW'(tp_ff) + MW'(fn_ff);
      p2     = MW'(fp_ff) + MW'(tn_ff);
      p3     = MW'(tp_ff) + MW'(fp_ff);
      p4     = MW'(fn_ff) + MW'(tn_ff);
      rs_sum = (FB + 2)'(rec_ff) + (FB + 2)'(spe_ff);
      mag    = neg_ff ? abb_ff - aba_ff : aba_ff - abb_ff;
      cand    = q_ff | (RW'(1) << k_ff);
      cand_sq = (2 * FB + 2)'(cand) * (2 * FB + 2)'(cand);
      if (p1 == '0 || p2 == '0 || p3 == '0 || p4 == '0) mcc_val = '0;
      else if (neg_ff) mcc_val = SW'(0) - SW'(q_ff);
      else mcc_val = SW'(q_ff);
   end

   // counter update for the accepted beat
   always_comb begin
      case ({req_predicted_positive, req_actual_positive})
         2'b11:   cur = tp_ff;
         2'b10:   cur = fp_ff;
         2'b01:   cur = fn_ff;
         default: cur = tn_ff;
      endcase
      sum_add = (CW + 1)'(cur) + (CW + 1)'(req_batch_count);
      upd     = cur;
      case (req_func)
         FUNC_ADD:    upd = sum_add[CW] ? '1 : sum_add[CW-1:0];
         FUNC_REMOVE: upd = (cur >= CW'(req_batch_count)) ? cur - CW'(req_batch_count) : '0;
         default:     upd = cur;
      endcase
   end

   // ratio operands
   always_comb begin
      num_q = '0;
      den_q = '0;
      case (job_ff)
         J_ACC: begin
            num_q = QW'(tp_ff) + QW'(tn_ff);
            den_q = QW'(total);
         end
         J_PRE: begin
            num_q = QW'(tp_ff);
            den_q = QW'(p3);
         end
         J_REC: begin
            num_q = QW'(tp_ff);
            den_q = QW'(p1);
         end
         J_SPE: begin
            num_q = QW'(tn_ff);
            den_q = QW'(p2);
         end
         J_F1: begin
            num_q = {QW'(tp_ff)} << 1;
            den_q = ({QW'(tp_ff)} << 1) + QW'(fn_ff) + QW'(fp_ff);
         end
         default: begin
            num_q = '0;
            den_q = '0;
         end
      endcase
      if (den_q == '0) qres = (job_ff == J_F1) ? ONE_Q : '0;
      else if (num_q >= den_q) qres = ONE_Q;
      else qres = alu_opb[FB:0];
   end

   // command for the shared unit
   always_comb begin
      acc_init = '0;
      opa_init = '0;
      opb_init = '0;
      ctl.start = (state_ff == ST_START);
      ctl.op    = ALU_DIV;
      ctl.steps = STEPW'(FB);
      case (job_ff)
         J_ACC, J_PRE, J_REC, J_SPE, J_F1: begin
            acc_init = UW'(num_q);
            opa_init = UW'(den_q);
         end
         J_HMUL: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(FB + 1);
            opa_init  = UW'(rec_ff);
            opb_init  = UW'(spe_ff);
         end
         J_HDIV: begin
            ctl.steps = STEPW'(2 * FB + 2);
            opa_init  = UW'(rs_sum);
            opb_init  = UW'({prod_ff, 1'b0}) << (UW - (2 * FB + 2));
         end
         J_AB1: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(CW);
            opa_init  = UW'(tp_ff);
            opb_init  = UW'(tn_ff);
         end
         J_AB2: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(CW);
            opa_init  = UW'(fp_ff);
            opb_init  = UW'(fn_ff);
         end
         J_MSQ: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(2 * CW);
            opa_init  = UW'(mag);
            opb_init  = UW'(mag);
         end
         J_D1: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(MW);
            opa_init  = UW'(p1);
            opb_init  = UW'(p2);
         end
         J_D2: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(MW);
            opa_init  = d_ff;
            opb_init  = UW'(p3);
         end
         J_D3: begin
            ctl.op    = ALU_MUL;
            ctl.steps = STEPW'(MW);
            opa_init  = d_ff;
            opb_init  = UW'(p4);
         end
         J_YDIV: begin
            ctl.steps = STEPW'(4 * CW + 2 * FB);
            opa_init  = d_ff;
            opb_init  = UW'(msq_ff) << (UW - 4 * CW);
         end
         default: begin
            acc_init = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      tp_in = tp_ff;
      fp_in = fp_ff;
      fn_in = fn_ff;
      tn_in = tn_ff;
      acc_q_in = acc_q_ff;
      pre_in   = pre_ff;
      rec_in   = rec_ff;
      spe_in   = spe_ff;
      f1_in    = f1_ff;
      hm_in    = hm_ff;
      prod_in  = prod_ff;
      aba_in   = aba_ff;
      abb_in   = abb_ff;
      neg_in   = neg_ff;
      msq_in   = msq_ff;
      d_in     = d_ff;
      y_in     = y_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      load_out = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == FUNC_CLEAR) begin
                  tp_in = '0;
                  fp_in = '0;
                  fn_in = '0;
                  tn_in = '0;
               end else begin
                  case ({req_predicted_positive, req_actual_positive})
                     2'b11:   tp_in = upd;
                     2'b10:   fp_in = upd;
                     2'b01:   fn_in = upd;
                     default: tn_in = upd;
                  endcase
               end
               job_in   = J_ACC;
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (!alu_busy) begin
               state_in = ST_START;
               job_in   = job_type'(4'(job_ff) + 4'd1);
               case (job_ff)
                  J_ACC:  acc_q_in = qres;
                  J_PRE:  pre_in = qres;
                  J_REC:  rec_in = qres;
                  J_SPE:  spe_in = qres;
                  J_F1:   f1_in = qres;
                  J_HMUL: prod_in = alu_acc[2*FB:0];
                  J_HDIV: hm_in = (rs_sum == '0) ? '0 : alu_opb[FB:0];
                  J_AB1:  aba_in = alu_acc[2*CW-1:0];
                  J_AB2: begin
                     abb_in = alu_acc[2*CW-1:0];
                     neg_in = alu_acc[2*CW-1:0] > aba_ff;
                  end
                  J_MSQ:  msq_in = alu_acc[4*CW-1:0];
                  J_D1, J_D2, J_D3: d_in = alu_acc;
                  J_YDIV: begin
                     y_in     = alu_opb[2*FB:0];
                     q_in     = '0;
                     k_in     = KW'(FB);
                     job_in   = J_ACC;
                     state_in = ST_SQRT;
                  end
                  default: state_in = ST_START;
               endcase
            end
         end
         ST_SQRT: begin
            // keep the candidate bit while its square does not exceed the quotient and it stays within 1.0
            if (cand <= ONE_Q && cand_sq <= (2 * FB + 2)'(y_ff)) q_in = cand;
            if (k_ff == '0) state_in = ST_FINISH;
            else k_in = k_ff - KW'(1);
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= J_ACC;
         tp_ff        <= '0;
         fp_ff        <= '0;
         fn_ff        <= '0;
         tn_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         tp_ff        <= tp_in;
         fp_ff        <= fp_in;
         fn_ff        <= fn_in;
         tn_ff        <= tn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_q_ff <= acc_q_in;
      pre_ff   <= pre_in;
      rec_ff   <= rec_in;
      spe_ff   <= spe_in;
      f1_ff    <= f1_in;
      hm_ff    <= hm_in;
      prod_ff  <= prod_in;
      aba_ff   <= aba_in;
      abb_ff   <= abb_in;
      neg_ff   <= neg_in;
      msq_ff   <= msq_in;
      d_ff     <= d_in;
      y_ff     <= y_in;
      q_ff     <= q_in;
      k_ff     <= k_in;
      if (load_out) begin
         o_tp_ff  <= tp_ff;
         o_fp_ff  <= fp_ff;
         o_fn_ff  <= fn_ff;
         o_tn_ff  <= tn_ff;
         o_tot_ff <= total;
         o_acc_ff <= acc_q_ff;
         o_pre_ff <= pre_ff;
         o_rec_ff <= rec_ff;
         o_spe_ff <= spe_ff;
         o_f1_ff  <= f1_ff;
         o_hm_ff  <= hm_ff;
         o_mcc_ff <= mcc_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_true_pos       = o_tp_ff;
   assign rsp_false_pos      = o_fp_ff;
   assign rsp_false_neg      = o_fn_ff;
   assign rsp_true_neg       = o_tn_ff;
   assign rsp_total_samples  = o_tot_ff;
   assign rsp_accuracy       = o_acc_ff;
   assign rsp_precision      = o_pre_ff;
   assign rsp_recall         = o_rec_ff;
   assign rsp_specificity    = o_spe_ff;
   assign rsp_f1_score       = o_f1_ff;
   assign rsp_mcc            = o_mcc_ff;
   assign rsp_sens_spec_mean = o_hm_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/cmm_checker.sv -----
// Port-level checks of the confusion-matrix metrics core, bound to the top level.
`default_nettype none
module cmm_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_ready,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire [cmm_pkg::CW-1:0]   rsp_true_pos,
   input wire [cmm_pkg::CW-1:0]   rsp_false_pos,
   input wire [cmm_pkg::CW-1:0]   rsp_false_neg,
   input wire [cmm_pkg::CW-1:0]   rsp_true_neg,
   input wire [cmm_pkg::TW-1:0]   rsp_total_samples,
   input wire [cmm_pkg::RW-1:0]   rsp_accuracy,
   input wire [cmm_pkg::RW-1:0]   rsp_precision,
   input wire [cmm_pkg::RW-1:0]   rsp_recall,
   input wire [cmm_pkg::RW-1:0]   rsp_specificity,
   input wire [cmm_pkg::RW-1:0]   rsp_f1_score,
   input wire [cmm_pkg::RW-1:0]   rsp_sens_spec_mean
);
   import cmm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while an item is in progress");

   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_total_samples == TW'(rsp_true_pos) + TW'(rsp_false_pos)
                    + TW'(rsp_false_neg) + TW'(rsp_true_neg))
      else $error("total does not match the counters");

   a_no_tp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_true_pos == '0 |-> rsp_precision == '0 && rsp_recall == '0)
      else $error("nonzero precision or recall without true positives");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_accuracy <= ONE_Q && rsp_f1_score <= ONE_Q
                    && rsp_sens_spec_mean <= ONE_Q && rsp_specificity <= ONE_Q)
      else $error("metric above 1.0");
endmodule

bind confusion_matrix_metrics_core cmm_checker u_cmm_checker (.*);
`default_nettype wire
